@@ design/double_hash_string_set_defines.svh @@
// Assertion macros for the set's datapath.
`ifndef DOUBLE_HASH_STRING_SET_DEFINES_SVH
`define DOUBLE_HASH_STRING_SET_DEFINES_SVH

// Property must hold on every rising edge of aclk outside reset.
`define DHSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition must never be true outside reset.
`define DHSS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

@@ design/dhss_pkg.sv @@
// Types, constants and helpers for the double-hash string set.
package dhss_pkg;

    localparam int MAX_SLOTS_DEF     = 1024;
    localparam int INITIAL_SLOTS_DEF = 8;
    localparam int MAX_KEY_CHARS_DEF = 8;
    localparam int KEY_W             = 64;
    localparam int BASE_W            = 16;
    localparam int CHAR_IDX_W        = 3;
    localparam int SECOND_BASE       = 137;
    localparam logic [BASE_W-1:0] FIRST_BASE_RST = 16'd113;
    localparam logic [1:0] ADDR_FIRST_BASE = 2'd0;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_TEST   = 2'd2,
        OP_RSVD   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_KEY     = 2'd1,
        ST_DELETED = 2'd2
    } slot_st_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_DECIDE,
        S_GROW_CLR,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SCAN_NEXT,
        S_PROBE_RD,
        S_PROBE_EV,
        S_RESP
    } state_t;

    typedef struct packed {
        logic load_user;
        logic reload_user;
        logic load_scan;
        logic hash_step;
        logic probe_init;
        logic probe_rd;
        logic probe_next;
        logic commit;
        logic grow;
        logic clr_all;
        logic clr_grow;
        logic grow_start;
        logic scan_rd;
        logic scan_next;
        logic grow_done;
        logic result_clr;
        logic out_load;
    } dhss_cmd_t;

    typedef struct packed {
        logic hash_last;
        logic key_zero;
        op_t  op;
        logic need_grow;
        logic clr_all_last;
        logic gclr_last;
        logic scan_last;
        logic scan_key;
        logic probe_done;
    } dhss_stat_t;

    // Keep bytes up to the first zero byte, at most nch of them.
    function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] k, input int nch);
        logic [KEY_W-1:0] o;
        logic run;
        o   = '0;
        run = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (i >= nch) run = 1'b0;
            if (k[8*i +: 8] == 8'd0) run = 1'b0;
            if (run) o[8*i +: 8] = k[8*i +: 8];
        end
        return o;
    endfunction

endpackage

@@ design/double_hash_string_set.sv @@
// Top level of the double-hash string set: APB register, controller and datapath.
//
// Input channel (s_valid/s_ready, s_opcode, s_key) takes one transaction per operation:
// insert, delete or membership test of a key of up to MAX_KEY_CHARS bytes, first byte low.
// Result channel (m_valid/m_ready, m_ok) returns one transaction per input: 1 when the
// key was inserted, deleted or found. Results come back in input order.
// Each operation passes through accept, hashing over all MAX_KEY_CHARS bytes, decide,
// a read and an evaluate step per probe, and response. The probe loop is bound by the
// registered read port of the slot memory.
// An insert that finds a table below MAX_SLOTS at least three quarters full first grows it:
// the new bank is cleared (one slot a cycle) and every held key is rehashed, each costing its own
// hash and probe time, before the insert itself runs.
// After reset the status memory of both banks (2*MAX_SLOTS entries) is cleared, one
// entry a cycle; s_ready stays low for those cycles. The APB port is live throughout.
// A result waits in the output register while m_ready is low; the next input is taken
// meanwhile, and its result holds until the register frees.
module double_hash_string_set
    import dhss_pkg::*;
#(
    parameter int MAX_SLOTS     = MAX_SLOTS_DEF,
    parameter int INITIAL_SLOTS = INITIAL_SLOTS_DEF,
    parameter int MAX_KEY_CHARS = MAX_KEY_CHARS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input transactions
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [KEY_W-1:0]  s_key,
    // result transactions
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_ok,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [BASE_W-1:0] first_base_reg;
    dhss_cmd_t         cmd;
    dhss_stat_t        st;

    // First-hash multiplier; the user must write it only while the block is idle, which the block does not enforce.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_base_reg <= FIRST_BASE_RST;
        end else if (psel && penable && pwrite && paddr == ADDR_FIRST_BASE) begin
            first_base_reg <= pwdata[BASE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_FIRST_BASE) ? {16'd0, first_base_reg} : 32'd0;

    dhss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    dhss_datapath #(
        .MAX_SLOTS     (MAX_SLOTS),
        .INITIAL_SLOTS (INITIAL_SLOTS),
        .MAX_KEY_CHARS (MAX_KEY_CHARS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .st         (st),
        .s_opcode   (s_opcode),
        .s_key      (s_key),
        .first_base (first_base_reg),
        .m_ok       (m_ok)
    );

endmodule

@@ design/dhss_ctrl.sv @@
// Sequencer for hashing, probing, growth and reset clearing.
module dhss_ctrl
    import dhss_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dhss_stat_t st,
    output dhss_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   grow_reg, grow_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            grow_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            grow_reg    <= grow_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        grow_next    = grow_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.grow     = grow_reg;
        s_ready      = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_all = 1'b1;
                if (st.clr_all_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_user = 1'b1;
                    state_next    = S_HASH;
                end
            end
            S_HASH: begin
                cmd.hash_step = 1'b1;
                if (st.hash_last) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (grow_reg) begin
                    cmd.probe_init = 1'b1;
                    state_next     = S_PROBE_RD;
                end else if (st.key_zero || st.op == OP_RSVD) begin
                    cmd.result_clr = 1'b1;
                    state_next     = S_RESP;
                end else if (st.op == OP_INSERT && st.need_grow) begin
                    cmd.grow_start = 1'b1;
                    grow_next      = 1'b1;
                    state_next     = S_GROW_CLR;
                end else begin
                    cmd.probe_init = 1'b1;
                    state_next     = S_PROBE_RD;
                end
            end
            S_GROW_CLR: begin
                cmd.clr_grow = 1'b1;
                if (st.gclr_last) state_next = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (st.scan_key) begin
                    cmd.load_scan = 1'b1;
                    state_next    = S_HASH;
                end else begin
                    state_next = S_SCAN_NEXT;
                end
            end
            S_SCAN_NEXT: begin
                if (st.scan_last) begin
                    cmd.grow_done   = 1'b1;
                    cmd.reload_user = 1'b1;
                    grow_next       = 1'b0;
                    state_next      = S_HASH;
                end else begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_PROBE_RD: begin
                cmd.probe_rd = 1'b1;
                state_next   = S_PROBE_EV;
            end
            S_PROBE_EV: begin
                if (st.probe_done) begin
                    cmd.commit = 1'b1;
                    state_next = grow_reg ? S_SCAN_NEXT : S_RESP;
                end else begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_PROBE_RD;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

@@ design/dhss_datapath.sv @@
// Key registers, hash units, probe logic, counters and slot memories.
`include "double_hash_string_set_defines.svh"
module dhss_datapath
    import dhss_pkg::*;
#(
    parameter int MAX_SLOTS     = MAX_SLOTS_DEF,
    parameter int INITIAL_SLOTS = INITIAL_SLOTS_DEF,
    parameter int MAX_KEY_CHARS = MAX_KEY_CHARS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dhss_cmd_t         cmd,
    output dhss_stat_t        st,
    input  logic [1:0]        s_opcode,
    input  logic [KEY_W-1:0]  s_key,
    input  logic [BASE_W-1:0] first_base,
    output logic              m_ok
);

    localparam int AW       = $clog2(MAX_SLOTS);
    localparam int MW       = AW + 1;
    localparam int CW       = AW + 1;
    localparam int LW       = $clog2(AW + 1);
    localparam int ILOG_RAW = $clog2(INITIAL_SLOTS);
    localparam int ILOG     = (ILOG_RAW > AW) ? AW : ILOG_RAW;
    localparam int DEPTH    = 2 * MAX_SLOTS;

    logic [1:0]       status_mem [DEPTH];
    logic [KEY_W-1:0] key_mem    [DEPTH];

    logic [KEY_W-1:0] ukey_reg, wkey_reg, rd_key_reg;
    op_t              op_reg;
    logic [AW-1:0]    h1_reg, h2_reg, idx_reg, step_reg, fdel_reg, scan_reg;
    logic [CHAR_IDX_W-1:0] cc_reg;
    logic             hstop_reg, has_del_reg, ok_reg, m_ok_reg, bank_reg;
    logic [CW-1:0]    pcnt_reg, live_reg, del_reg, n_reg;
    logic [LW-1:0]    caplog_reg;
    logic [MW-1:0]    clr_reg;
    logic [1:0]       rd_status_reg;

    logic [CW-1:0]    cap, newcap, pcap;
    logic [LW-1:0]    plog;
    logic [AW-1:0]    pmask, hv1, hv2;
    logic             pbank;
    logic [7:0]       ch;
    logic [2*AW-1:0]  p1, p2;
    logic [AW+3:0]    occ4, lim3;
    logic             cur_empty, cur_del, cur_match, pr_last, place_mode;
    logic             pr_done, pr_ok, pr_tomb;
    logic [AW-1:0]    pr_pos;
    logic             st_we, key_we, rd_en;
    logic [MW-1:0]    st_wa, rd_a;
    logic [1:0]       st_wd;

    assign cap    = CW'(1) << caplog_reg;
    assign newcap = cap << 1;
    assign plog   = cmd.grow ? caplog_reg + LW'(1) : caplog_reg;
    assign pcap   = CW'(1) << plog;
    assign pmask  = AW'(pcap - CW'(1));
    assign pbank  = cmd.grow ? ~bank_reg : bank_reg;

    // Horner step, one character a cycle; only the low AW bits matter.
    assign ch  = wkey_reg[{cc_reg, 3'b000} +: 8];
    assign p1  = h1_reg * AW'(first_base);
    assign p2  = h2_reg * AW'(SECOND_BASE);
    assign hv1 = {h1_reg[AW-2:0], 1'b1};
    assign hv2 = {h2_reg[AW-2:0], 1'b1};

    assign occ4 = ((AW+4)'(live_reg) + (AW+4)'(del_reg)) << 2;
    assign lim3 = (AW+4)'(cap) * (AW+4)'(3);

    assign cur_empty  = rd_status_reg == ST_EMPTY;
    assign cur_del    = rd_status_reg == ST_DELETED;
    assign cur_match  = (rd_status_reg == ST_KEY) && (rd_key_reg == wkey_reg);
    assign pr_last    = pcnt_reg == pcap - CW'(1);
    assign place_mode = cmd.grow || op_reg == OP_INSERT;

    always_comb begin
        pr_done = 1'b0;
        pr_ok   = 1'b0;
        pr_tomb = 1'b0;
        pr_pos  = idx_reg;
        if (place_mode) begin
            priority if (cur_empty) begin
                pr_done = 1'b1;
                pr_ok   = 1'b1;
                pr_tomb = has_del_reg;
                pr_pos  = has_del_reg ? fdel_reg : idx_reg;
            end else if (cur_match) begin
                pr_done = 1'b1;
            end else if (pr_last) begin
                pr_done = 1'b1;
                if (has_del_reg || cur_del) begin
                    pr_ok   = 1'b1;
                    pr_tomb = 1'b1;
                    pr_pos  = has_del_reg ? fdel_reg : idx_reg;
                end
            end
        end else begin
            priority if (cur_empty) begin
                pr_done = 1'b1;
            end else if (cur_match) begin
                pr_done = 1'b1;
                pr_ok   = 1'b1;
            end else if (pr_last) begin
                pr_done = 1'b1;
            end
        end
    end

    // Slot memory write/read port selection.
    always_comb begin
        st_we  = 1'b0;
        st_wa  = clr_reg;
        st_wd  = ST_EMPTY;
        key_we = 1'b0;
        if (cmd.clr_all) begin
            st_we = 1'b1;
        end else if (cmd.clr_grow) begin
            st_we = 1'b1;
            st_wa = {~bank_reg, clr_reg[AW-1:0]};
        end else if (cmd.commit && pr_ok && (place_mode || op_reg == OP_DELETE)) begin
            st_we  = 1'b1;
            st_wa  = {pbank, pr_pos};
            st_wd  = place_mode ? ST_KEY : ST_DELETED;
            key_we = place_mode;
        end
        rd_en = cmd.scan_rd || cmd.probe_rd;
        rd_a  = cmd.scan_rd ? {bank_reg, scan_reg} : {pbank, idx_reg};
    end

    always_ff @(posedge aclk) begin
        if (st_we) status_mem[st_wa] <= st_wd;
        if (rd_en) rd_status_reg <= status_mem[rd_a];
    end

    always_ff @(posedge aclk) begin
        if (key_we) key_mem[st_wa] <= wkey_reg;
        if (rd_en) rd_key_reg <= key_mem[rd_a];
    end

    // Table geometry and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg   <= 1'b0;
            caplog_reg <= LW'(ILOG);
            live_reg   <= '0;
            del_reg    <= '0;
            clr_reg    <= '0;
        end else begin
            if (cmd.grow_start) clr_reg <= '0;
            else if (cmd.clr_all || cmd.clr_grow) clr_reg <= clr_reg + MW'(1);
            if (cmd.grow_done) begin
                bank_reg   <= ~bank_reg;
                caplog_reg <= caplog_reg + LW'(1);
                live_reg   <= n_reg;
                del_reg    <= '0;
            end else if (cmd.commit && pr_ok && !cmd.grow) begin
                if (op_reg == OP_INSERT) begin
                    live_reg <= live_reg + CW'(1);
                    if (pr_tomb && del_reg != '0) del_reg <= del_reg - CW'(1);
                end else if (op_reg == OP_DELETE) begin
                    if (live_reg != '0) live_reg <= live_reg - CW'(1);
                    del_reg <= del_reg + CW'(1);
                end
            end
        end
    end

    // Work registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_user) begin
            ukey_reg <= canon_key(s_key, MAX_KEY_CHARS);
            op_reg   <= op_t'(s_opcode);
        end
        if (cmd.load_user) wkey_reg <= canon_key(s_key, MAX_KEY_CHARS);
        else if (cmd.reload_user) wkey_reg <= ukey_reg;
        else if (cmd.load_scan) wkey_reg <= rd_key_reg;

        if (cmd.load_user || cmd.reload_user || cmd.load_scan) begin
            h1_reg    <= '0;
            h2_reg    <= '0;
            cc_reg    <= '0;
            hstop_reg <= 1'b0;
        end else if (cmd.hash_step) begin
            cc_reg <= cc_reg + CHAR_IDX_W'(1);
            if (!hstop_reg) begin
                if (ch == 8'd0) begin
                    hstop_reg <= 1'b1;
                end else begin
                    h1_reg <= p1[AW-1:0] + AW'(ch);
                    h2_reg <= p2[AW-1:0] + AW'(ch);
                end
            end
        end

        if (cmd.probe_init) begin
            idx_reg     <= hv1 & pmask;
            step_reg    <= hv2 & pmask;
            pcnt_reg    <= '0;
            has_del_reg <= 1'b0;
        end else if (cmd.probe_next) begin
            idx_reg  <= (idx_reg + step_reg) & pmask;
            pcnt_reg <= pcnt_reg + CW'(1);
            if (cur_del && !has_del_reg) begin
                has_del_reg <= 1'b1;
                fdel_reg    <= idx_reg;
            end
        end

        if (cmd.grow_start) begin
            scan_reg <= '0;
            n_reg    <= '0;
        end else begin
            if (cmd.scan_next) scan_reg <= scan_reg + AW'(1);
            if (cmd.commit && pr_ok && cmd.grow) n_reg <= n_reg + CW'(1);
        end

        if (cmd.result_clr) ok_reg <= 1'b0;
        else if (cmd.commit && !cmd.grow) ok_reg <= pr_ok;
        if (cmd.out_load) m_ok_reg <= ok_reg;
    end

    assign st.hash_last    = cc_reg == CHAR_IDX_W'(MAX_KEY_CHARS - 1);
    assign st.key_zero     = ukey_reg == '0;
    assign st.op           = op_reg;
    assign st.need_grow    = (occ4 >= lim3) && (caplog_reg < LW'(AW));
    assign st.clr_all_last = clr_reg == MW'(DEPTH - 1);
    assign st.gclr_last    = clr_reg == newcap - CW'(1);
    assign st.scan_last    = scan_reg == AW'(cap - CW'(1));
    assign st.scan_key     = rd_status_reg == ST_KEY;
    assign st.probe_done   = pr_done;
    assign m_ok            = m_ok_reg;

    `DHSS_ASSERT(a_occ_bound, ((CW+1)'(live_reg) + (CW+1)'(del_reg)) <= (CW+1)'(cap), "occupancy above capacity")
    `DHSS_ASSERT(a_bank_grows, !$stable(bank_reg) |-> (caplog_reg == $past(caplog_reg) + LW'(1)), "bank swap without growth")
    `DHSS_ASSERT_NEVER(a_commit_in_clear, cmd.commit && (cmd.clr_all || cmd.clr_grow), "commit during clear sweep")

endmodule

@@ bench/tb_double_hash_string_set.sv @@
// Self-checking bench for the double-hash string set: scoreboard with a table predictor.
module tb_double_hash_string_set;
    import dhss_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS    = MAX_SLOTS_DEF;
    localparam int TOP_LOG  = $clog2(MAX_SLOTS_DEF);
    localparam int INIT_LOG = $clog2(INITIAL_SLOTS_DEF);

    // Tracks the expected set contents and the queue of pending ok bits.
    class set_scoreboard;
        slot_st_t         st_mem[2][SLOTS];
        logic [KEY_W-1:0] key_mem[2][SLOTS];
        int               bank, lg, live, dead;
        logic [15:0]      base1;
        bit               exp_ok[$];
        int               errors;

        function new();
            for (int b = 0; b < 2; b++)
                for (int i = 0; i < SLOTS; i++) st_mem[b][i] = ST_EMPTY;
            bank = 0; lg = INIT_LOG; live = 0; dead = 0;
            base1 = FIRST_BASE_RST; errors = 0;
        endfunction

        function logic [63:0] poly(logic [63:0] k, logic [63:0] mult);
            logic [63:0] h;
            h = 0;
            for (int i = 0; i < MAX_KEY_CHARS_DEF; i++) begin
                if (k[8*i +: 8] == 8'd0) break;
                h = h * mult + 64'(k[8*i +: 8]);
            end
            return h * 2 + 1;
        endfunction

        function logic [63:0] trim(logic [63:0] k);
            logic [63:0] o;
            o = 0;
            for (int i = 0; i < MAX_KEY_CHARS_DEF; i++) begin
                if (k[8*i +: 8] == 8'd0) break;
                o[8*i +: 8] = k[8*i +: 8];
            end
            return o;
        endfunction

        // 0: present or no room, 1: empty slot used, 2: tombstone reused
        function int place(int b, int l, logic [63:0] k, logic [63:0] h1, logic [63:0] h2);
            int cap, idx, fd, pos;
            bit hd;
            cap = 1 << l; idx = int'(h1 & 64'(cap - 1)); hd = 0; fd = 0;
            for (int i = 0; i < cap; i++) begin
                if (st_mem[b][idx] == ST_EMPTY) begin
                    pos = hd ? fd : idx;
                    key_mem[b][pos] = k; st_mem[b][pos] = ST_KEY;
                    return hd ? 2 : 1;
                end
                if (st_mem[b][idx] == ST_KEY) begin
                    if (key_mem[b][idx] == k) return 0;
                end else if (!hd) begin
                    hd = 1; fd = idx;
                end
                idx = int'((64'(idx) + h2) & 64'(cap - 1));
            end
            if (hd) begin
                key_mem[b][fd] = k; st_mem[b][fd] = ST_KEY;
                return 2;
            end
            return 0;
        endfunction

        function int lookup(logic [63:0] k);
            int cap, idx;
            logic [63:0] h2;
            cap = 1 << lg; h2 = poly(k, SECOND_BASE);
            idx = int'(poly(k, 64'(base1)) & 64'(cap - 1));
            for (int i = 0; i < cap; i++) begin
                if (st_mem[bank][idx] == ST_EMPTY) return cap;
                if (st_mem[bank][idx] == ST_KEY && key_mem[bank][idx] == k) return idx;
                idx = int'((64'(idx) + h2) & 64'(cap - 1));
            end
            return cap;
        endfunction

        function void grow();
            int nb, n;
            nb = bank ^ 1; n = 0;
            for (int i = 0; i < SLOTS; i++) st_mem[nb][i] = ST_EMPTY;
            for (int i = 0; i < (1 << lg); i++)
                if (st_mem[bank][i] == ST_KEY &&
                    place(nb, lg + 1, key_mem[bank][i], poly(key_mem[bank][i], 64'(base1)),
                          poly(key_mem[bank][i], SECOND_BASE)) != 0)
                    n++;
            live = n; dead = 0; bank = nb; lg = lg + 1;
        endfunction

        // Accepted input transaction: update the table, queue the expected ok.
        function void note_input(logic [1:0] op, logic [63:0] raw);
            logic [63:0] k;
            int r, pos;
            bit ok;
            k = trim(raw); ok = 0;
            if (k != 0) begin
                case (op_t'(op))
                    OP_INSERT: begin
                        if ((live + dead) * 4 >= (1 << lg) * 3 && lg < TOP_LOG) grow();
                        r = place(bank, lg, k, poly(k, 64'(base1)), poly(k, SECOND_BASE));
                        if (r != 0) begin
                            live++;
                            if (r == 2 && dead > 0) dead--;
                            ok = 1;
                        end
                    end
                    OP_DELETE: begin
                        pos = lookup(k);
                        if (pos < (1 << lg)) begin
                            st_mem[bank][pos] = ST_DELETED;
                            if (live > 0) live--;
                            dead++;
                            ok = 1;
                        end
                    end
                    OP_TEST: ok = lookup(k) < (1 << lg);
                    default: ok = 0;
                endcase
            end
            exp_ok.push_back(ok);
        endfunction

        function void check_result(bit got);
            bit want;
            if (exp_ok.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transaction, ok=%0b", got);
                return;
            end
            want = exp_ok.pop_front();
            if (want != got) begin
                errors++;
                if (errors <= 10) $display("ok mismatch: expected %0b, got %0b", want, got);
            end
        endfunction
    endclass

    logic             aclk, aresetn;
    logic             s_valid, s_ready;
    logic [1:0]       s_opcode;
    logic [KEY_W-1:0] s_key;
    logic             m_valid, m_ready, m_ok;
    logic             psel, penable, pwrite;
    logic [1:0]       paddr;
    logic [31:0]      pwdata, prdata;
    logic             pready;

    set_scoreboard    sb;
    int               send_idle, recv_idle;
    logic [63:0]      key_pool[$];

    double_hash_string_set dut (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #200ms;
        $display("FAIL");
        $finish;
    end

    // Result side: check at each handshake, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_ok);
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle);
    end

    // Drop valid and scramble the idle payload.
    task automatic end_input();
        s_valid  <= 1'b0;
        s_opcode <= 2'($urandom);
        s_key    <= {$urandom, $urandom};
    endtask

    // One input transaction, with optional idle cycles ahead of it.
    // Valid stays high after the handshake so back-to-back transactions need no gap.
    task automatic send(logic [1:0] op, logic [63:0] k);
        if ($urandom_range(99) < send_idle) begin
            end_input();
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_key    <= k;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(op, k);
    endtask

    // Register write, only with nothing in flight.
    task automatic write_base(logic [15:0] v);
        end_input();
        while (sb.exp_ok.size() != 0) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FIRST_BASE;
        pwdata  <= {16'($urandom), v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.base1 = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Lowercase key of n letters; junk may follow the terminating zero byte.
    function automatic logic [63:0] letters(int n);
        logic [63:0] k;
        k = {$urandom, $urandom};
        for (int i = 0; i < 8; i++) begin
            if (i < n) k[8*i +: 8] = 8'(8'd97 + $urandom_range(25));
            else if (i == n) k[8*i +: 8] = 8'd0;
            else if ($urandom_range(1)) k[8*i +: 8] = 8'd0;
        end
        return k;
    endfunction

    function automatic logic [63:0] fresh_key();
        logic [63:0] k;
        if ($urandom_range(9) == 0) k = {$urandom, $urandom};  // arbitrary bytes
        else k = letters($urandom_range(1, 8));
        key_pool.push_back(k);
        return k;
    endfunction

    // Mixed traffic: keys already seen are reused (share set by pct_fresh) so hits, deletes and reuse occur.
    task automatic random_traffic(int n, int pct_insert, int pct_fresh);
        int r;
        logic [1:0]  op;
        logic [63:0] k;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < pct_insert) op = OP_INSERT;
            else if (r < pct_insert + (100 - pct_insert) / 2) op = OP_DELETE;
            else op = OP_TEST;
            if ($urandom_range(49) == 0) op = OP_RSVD;
            if ($urandom_range(99) == 0) k = {$urandom, $urandom} & 64'hFFFF_FF00_0000_0000;
            else if (key_pool.size() == 0 || $urandom_range(99) < pct_fresh) k = fresh_key();
            else k = key_pool[$urandom_range(key_pool.size() - 1)];
            send(op, k);
        end
    endtask

    initial begin
        sb       = new();
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_opcode = '0;
        s_key    = '0;
        m_ready  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        send_idle = 24;
        recv_idle = 73;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: duplicates, tombstone reuse, empty keys, reserved op, odd bytes.
        send(OP_TEST,   64'h61);
        send(OP_INSERT, 64'h61);
        send(OP_INSERT, 64'h61);
        send(OP_TEST,   64'h61);
        send(OP_DELETE, 64'h61);
        send(OP_TEST,   64'h61);
        send(OP_DELETE, 64'h61);
        send(OP_INSERT, 64'h61);
        send(OP_INSERT, 64'h0);
        send(OP_DELETE, 64'hFFFF_FFFF_FFFF_FF00);
        send(OP_TEST,   64'h0);
        send(OP_RSVD,   64'h6362_61);
        send(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send(OP_TEST,   64'hFFFF_FFFF_FFFF_FFFF);
        send(OP_INSERT, 64'hDEAD_0000_0000_6261);
        send(OP_TEST,   64'h6261);
        send(OP_INSERT, 64'h2120_7F80_0130_7A41);
        for (int i = 0; i < 6; i++) send(OP_INSERT, fresh_key());
        send(OP_DELETE, 64'hFFFF_FFFF_FFFF_FFFF);
        send(OP_TEST,   64'h61);

        // Largest base, keys still held from the default base.
        write_base(16'hFFFF);
        random_traffic(350, 55, 20);

        send_idle = 73;
        recv_idle = 24;
        write_base(16'd1);
        random_traffic(350, 55, 20);

        // No idling; insert-heavy fill drives the table to its top size and past full.
        send_idle = 0;
        recv_idle = 0;
        write_base(16'($urandom_range(2, 65534)));
        random_traffic(1250, 85, 90);

        end_input();
        while (sb.exp_ok.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
